// ----- hw/rtl/cstr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the comment stripper.
// Used by the channel interfaces, the front end, the queue and the back end.

package cstr_pkg;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 2;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

    // Number of bytes carried by one queue entry.
    localparam logic [CNT_W-1:0] NB_NONE = 2'd0;
    localparam logic [CNT_W-1:0] NB_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] NB_TWO  = 2'd2;

    // What one accepted input item leaves for the back end.
    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [CNT_W-1:0]  n_bytes;
        logic              fin;
    } q_entry_t;

endpackage

// ----- hw/rtl/cstr_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the comment stripper: one source text byte per item.
// Depends on cstr_pkg for the byte width.

interface cstr_in_if;
    import cstr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              is_final;

    modport source (output valid, output text_byte, output is_final, input ready);
    modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

// ----- hw/rtl/cstr_out_if.sv -----
`timescale 1ns / 1ps
// Output channel of the comment stripper: one result byte or end marker per item.
// Depends on cstr_pkg for the byte width.

interface cstr_out_if;
    import cstr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              text_end;

    modport source (output valid, output out_byte, output byte_valid,
                    output run_last, output text_end, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input run_last, input text_end, output ready);
endinterface

// ----- hw/rtl/cstr_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts source bytes, tracks the lexical mode and classifies
// each byte into the bytes it releases. Depends on cstr_pkg.

module cstr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               in_final,
    input  logic               q_full,
    output logic               q_push,
    output cstr_pkg::q_entry_t q_data
);
    import cstr_pkg::*;

    localparam logic [3:0] MODE_CODE       = 4'd0;
    localparam logic [3:0] MODE_SLASH      = 4'd1;
    localparam logic [3:0] MODE_LINE       = 4'd2;
    localparam logic [3:0] MODE_BLOCK      = 4'd3;
    localparam logic [3:0] MODE_BLOCK_STAR = 4'd4;
    localparam logic [3:0] MODE_STR        = 4'd5;
    localparam logic [3:0] MODE_STR_ESC    = 4'd6;
    localparam logic [3:0] MODE_CHR        = 4'd7;
    localparam logic [3:0] MODE_CHR_ESC    = 4'd8;

    logic [3:0] mode_reg;
    logic [3:0] mode_next;
    q_entry_t   ent;
    logic       accept;

    function automatic q_entry_t add_byte(input q_entry_t e, input logic [BYTE_W-1:0] b);
        q_entry_t r;
        r = e;
        if (e.n_bytes == NB_NONE)
        begin
            r.byte0 = b;
        end
        else
        begin
            r.byte1 = b;
        end
        r.n_bytes = e.n_bytes + NB_ONE;
        return r;
    endfunction

    always_comb
    begin
        mode_next   = mode_reg;
        ent         = '0;
        ent.fin     = in_final;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = MODE_LINE;
                end
                else if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
                else
                begin
                    // The held slash was plain code; release it, then treat
                    // this byte as code.
                    ent = add_byte(ent, CH_SLASH);
                    if (in_byte == CH_DQUOTE)
                    begin
                        ent       = add_byte(ent, in_byte);
                        mode_next = MODE_STR;
                    end
                    else if (in_byte == CH_SQUOTE)
                    begin
                        ent       = add_byte(ent, in_byte);
                        mode_next = MODE_CHR;
                    end
                    else
                    begin
                        ent       = add_byte(ent, in_byte);
                        mode_next = MODE_CODE;
                    end
                end
            end
            MODE_LINE:
            begin
                if (in_byte == CH_NL)
                begin
                    ent       = add_byte(ent, in_byte);
                    mode_next = MODE_CODE;
                end
            end
            MODE_BLOCK, MODE_BLOCK_STAR:
            begin
                if (mode_reg == MODE_BLOCK_STAR && in_byte == CH_SLASH)
                begin
                    mode_next = MODE_CODE;
                end
                else if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCK_STAR;
                end
                else
                begin
                    if (in_byte == CH_NL)
                    begin
                        ent = add_byte(ent, in_byte);
                    end
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_STR:
            begin
                ent = add_byte(ent, in_byte);
                if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_STR_ESC;
                end
                else if (in_byte == CH_DQUOTE)
                begin
                    mode_next = MODE_CODE;
                end
            end
            MODE_STR_ESC:
            begin
                ent       = add_byte(ent, in_byte);
                mode_next = MODE_STR;
            end
            MODE_CHR:
            begin
                ent = add_byte(ent, in_byte);
                if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_CHR_ESC;
                end
                else if (in_byte == CH_SQUOTE)
                begin
                    mode_next = MODE_CODE;
                end
            end
            MODE_CHR_ESC:
            begin
                ent       = add_byte(ent, in_byte);
                mode_next = MODE_CHR;
            end
            default:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else if (in_byte == CH_DQUOTE)
                begin
                    ent       = add_byte(ent, in_byte);
                    mode_next = MODE_STR;
                end
                else if (in_byte == CH_SQUOTE)
                begin
                    ent       = add_byte(ent, in_byte);
                    mode_next = MODE_CHR;
                end
                else
                begin
                    ent       = add_byte(ent, in_byte);
                    mode_next = MODE_CODE;
                end
            end
        endcase

        // At the end of the text a slash still held is released and the
        // lexer goes back to plain code.
        if (in_final)
        begin
            if (mode_next == MODE_SLASH)
            begin
                ent = add_byte(ent, CH_SLASH);
            end
            mode_next = MODE_CODE;
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_data   = ent;
    // Items that release nothing and do not end the text leave no entry.
    assign q_push   = accept && (in_final || ent.n_bytes != NB_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CODE;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ----- hw/rtl/cstr_fifo.sv -----
`timescale 1ns / 1ps
// Short queue between the front end and the back end of the comment stripper.
// Depends on cstr_pkg for the entry type and depth.

module cstr_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cstr_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output cstr_pkg::q_entry_t head
);
    import cstr_pkg::*;

    q_entry_t           mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;
    logic               do_pop;

    assign full      = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/cstr_back.sv -----
`timescale 1ns / 1ps
// Back end: turns queue entries into result items, one or two per entry.
// Depends on cstr_pkg for the entry type.

module cstr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  cstr_pkg::q_entry_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               run_last,
    output logic               text_end
);
    import cstr_pkg::*;

    // Set while the second byte of a two-byte entry is on show.
    logic phase_reg;
    logic phase_next;
    logic two;
    logic take;

    assign two       = (q_head.n_bytes == NB_TWO);
    assign out_valid = q_not_empty;
    assign take      = out_valid && out_ready;
    assign q_pop     = take && (phase_reg || !two);

    always_comb
    begin
        if (phase_reg)
        begin
            out_byte   = q_head.byte1;
            byte_valid = 1'b1;
            run_last   = 1'b1;
            text_end   = q_head.fin;
        end
        else
        begin
            byte_valid = (q_head.n_bytes != NB_NONE);
            out_byte   = byte_valid ? q_head.byte0 : '0;
            run_last   = !two;
            text_end   = q_head.fin && !two;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            phase_next = !phase_reg && two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// ----- hw/rtl/c_comment_stripper.sv -----
`timescale 1ns / 1ps
// C/C++ comment stripper. The first result of an item is offered from its
// registered queue entry, after any entries queued ahead of it.
// Throughput: one input item per cycle while the queue is not full; an item
// releasing two bytes yields two results; the four-entry queue absorbs bursts.
// Reset: lexer returns to plain code mode, queue empties, no result is offered.

module c_comment_stripper (
    input  logic        clk,
    input  logic        rst_n,
    cstr_in_if.sink     in_ch,
    cstr_out_if.source  out_ch
);
    import cstr_pkg::*;

    q_entry_t push_data;
    q_entry_t head;
    logic     push;
    logic     full;
    logic     pop;
    logic     not_empty;

    cstr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_byte  (in_ch.text_byte),
        .in_final (in_ch.is_final),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    cstr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    cstr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (not_empty),
        .q_head      (head),
        .q_pop       (pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_byte    (out_ch.out_byte),
        .byte_valid  (out_ch.byte_valid),
        .run_last    (out_ch.run_last),
        .text_end    (out_ch.text_end)
    );

endmodule

// ----- hw/rtl/cstr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the comment stripper, bound to the top level.
// Depends only on the top level's channel signals.

module cstr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       text_end
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(run_last) && $stable(text_end))
        else $error("result changed while stalled");

    // A bare end marker carries a zero byte and closes both the item and the text.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00 && run_last && text_end)
        else $error("malformed end marker");

    // The end of the text is always the last result of its item.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_last)
        else $error("text end before last result of item");

    // The second byte of a pair is already queued, so it follows at once.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid && byte_valid)
        else $error("second result of an item not offered next");

endmodule

bind c_comment_stripper cstr_checker u_cstr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .byte_valid (out_ch.byte_valid),
    .run_last   (out_ch.run_last),
    .text_end   (out_ch.text_end)
);

// ----- test/tb_c_comment_stripper.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for c_comment_stripper: a short table of directed bytes,
// then random C-like texts, checked against hand results or a lexer model in this file.
// Depends on cstr_pkg and the cstr_in_if / cstr_out_if channel interfaces.

module tb_c_comment_stripper;
    import cstr_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RAND_ITEMS  = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int DIR_N       = 28;
    localparam int DRAIN_WAIT  = 8;

    typedef enum logic [3:0] {
        LX_CODE, LX_SLASH, LX_LINE, LX_BLOCK, LX_BLOCK_STAR,
        LX_STR, LX_STR_ESC, LX_CHR, LX_CHR_ESC
    } lex_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              text_end;
    } strip_res_t;

    // Results written by hand for one input item; typed = 0 leaves it to the lexer model.
    typedef struct packed {
        logic             typed;
        logic [CNT_W-1:0] n_res;
        strip_res_t       res0;
        strip_res_t       res1;
    } hand_exp_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              is_final;
        hand_exp_t         hand;
    } dir_row_t;

    localparam strip_res_t NO_RES = '0;

    logic clk;
    logic rst_n;

    cstr_in_if  in_ch ();
    cstr_out_if out_ch ();

    c_comment_stripper dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lex_mode_t         lex_mode = LX_CODE;
    strip_res_t        strip_q [$];
    hand_exp_t         hand_q [$];
    logic [BYTE_W-1:0] txt [$];
    int                errors      = 0;
    int                reports     = 0;
    int                items_in    = 0;
    int                results_out = 0;
    int                texts       = 0;
    int                cycle_cnt   = 0;
    bit                calm        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 17);
    endfunction

    // Appends to the tail of each of the three queues.
    function automatic void strip_add(input strip_res_t r);
        strip_q.insert(strip_q.size(), r);
    endfunction

    function automatic void hand_add(input hand_exp_t h);
        hand_q.insert(hand_q.size(), h);
    endfunction

    function automatic void txt_add(input logic [BYTE_W-1:0] b);
        txt.insert(txt.size(), b);
    endfunction

    // Mostly printable text, with the odd byte from the full range.
    function automatic logic [BYTE_W-1:0] pick_body();
        if ($urandom_range(0, 7) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return BYTE_W'($urandom_range(8'h20, 8'h7E));
    endfunction

    // Advances the lexer by one byte; when keep is set, queues the results it causes.
    function automatic void strip_predict(input logic [BYTE_W-1:0] b, input logic fin,
                                          input bit keep);
        logic [BYTE_W-1:0] ch [2];
        int                n;
        bit                as_code;
        n = 0;
        as_code = 1'b0;
        case (lex_mode)
            LX_SLASH:
                if (b == CH_SLASH)
                    lex_mode = LX_LINE;
                else if (b == CH_STAR)
                    lex_mode = LX_BLOCK;
                else
                begin
                    ch[n] = CH_SLASH;
                    n++;
                    as_code = 1'b1;
                end
            LX_LINE:
                if (b == CH_NL)
                begin
                    ch[n] = b;
                    n++;
                    lex_mode = LX_CODE;
                end
            LX_BLOCK, LX_BLOCK_STAR:
                if (lex_mode == LX_BLOCK_STAR && b == CH_SLASH)
                    lex_mode = LX_CODE;
                else if (b == CH_STAR)
                    lex_mode = LX_BLOCK_STAR;
                else
                begin
                    if (b == CH_NL)
                    begin
                        ch[n] = b;
                        n++;
                    end
                    lex_mode = LX_BLOCK;
                end
            LX_STR, LX_CHR:
            begin
                ch[n] = b;
                n++;
                if (b == CH_BSLASH)
                    lex_mode = (lex_mode == LX_STR) ? LX_STR_ESC : LX_CHR_ESC;
                else if (b == ((lex_mode == LX_STR) ? CH_DQUOTE : CH_SQUOTE))
                    lex_mode = LX_CODE;
            end
            LX_STR_ESC:
            begin
                ch[n] = b;
                n++;
                lex_mode = LX_STR;
            end
            LX_CHR_ESC:
            begin
                ch[n] = b;
                n++;
                lex_mode = LX_CHR;
            end
            default:
                as_code = 1'b1;
        endcase

        // Plain code handling, also for the byte that follows a released slash.
        if (as_code)
        begin
            if (b == CH_SLASH)
                lex_mode = LX_SLASH;
            else
            begin
                ch[n] = b;
                n++;
                if (b == CH_DQUOTE)
                    lex_mode = LX_STR;
                else if (b == CH_SQUOTE)
                    lex_mode = LX_CHR;
                else
                    lex_mode = LX_CODE;
            end
        end

        if (fin)
        begin
            if (lex_mode == LX_SLASH)
            begin
                ch[n] = CH_SLASH;
                n++;
            end
            lex_mode = LX_CODE;
        end

        if (keep)
        begin
            for (int k = 0; k < n; k++)
                strip_add(strip_res_t'{ch[k], 1'b1, k == n - 1, fin && (k == n - 1)});
            if (fin && n == 0)
                strip_add(strip_res_t'{'0, 1'b0, 1'b1, 1'b1});
        end
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin,
                             input hand_exp_t h);
        while (idle_roll())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        hand_add(h);
        in_ch.valid     <= 1'b1;
        in_ch.text_byte <= b;
        in_ch.is_final  <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= !idle_roll();
        end
    end

    // Predicts on every accepted input item and checks every accepted result item.
    always @(posedge clk)
    begin
        hand_exp_t  h;
        strip_res_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                h = hand_q.pop_front();
                strip_predict(in_ch.text_byte, in_ch.is_final, !h.typed);
                if (h.typed && h.n_res != NB_NONE)
                    strip_add(h.res0);
                if (h.typed && h.n_res == NB_TWO)
                    strip_add(h.res1);
                items_in++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_out++;
                if (strip_q.size() == 0)
                begin
                    errors++;
                    if (reports < MAX_REPORTS)
                        $display("Result item %0d arrived with nothing expected: byte %h",
                                 results_out, out_ch.out_byte);
                    reports++;
                end
                else
                begin
                    want = strip_q.pop_front();
                    if (out_ch.out_byte !== want.out_byte
                        || out_ch.byte_valid !== want.byte_valid
                        || out_ch.run_last !== want.run_last
                        || out_ch.text_end !== want.text_end)
                    begin
                        errors++;
                        if (reports < MAX_REPORTS)
                            $display({"Result item %0d: expected byte %h valid %b last %b ",
                                      "end %b, got byte %h valid %b last %b end %b"},
                                     results_out, want.out_byte, want.byte_valid,
                                     want.run_last, want.text_end, out_ch.out_byte,
                                     out_ch.byte_valid, out_ch.run_last, out_ch.text_end);
                        reports++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     strip_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        dir_row_t          rows [DIR_N];
        int                items_sent;
        int                cut;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.text_byte <= '0;
        in_ch.is_final  <= 1'b0;
        items_sent = 0;

        // Bytes 61, 78, 6B are 'a', 'x', 'k'.
        rows = '{
            '{8'h61,     1'b0, '{1'b1, NB_ONE,  '{8'h61, 1'b1, 1'b1, 1'b0}, NO_RES}},
            '{8'h00,     1'b0, '{1'b1, NB_ONE,  '{8'h00, 1'b1, 1'b1, 1'b0}, NO_RES}},
            '{8'hFF,     1'b0, '{1'b1, NB_ONE,  '{8'hFF, 1'b1, 1'b1, 1'b0}, NO_RES}},
            '{CH_SLASH,  1'b0, '{1'b1, NB_NONE, NO_RES, NO_RES}},
            '{8'h78,     1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SLASH,  1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SLASH,  1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_NL,     1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SLASH,  1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_STAR,   1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_STAR,   1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_STAR,   1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_NL,     1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_STAR,   1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SLASH,  1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_DQUOTE, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SLASH,  1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_BSLASH, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_DQUOTE, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_DQUOTE, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SQUOTE, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_BSLASH, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SQUOTE, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SQUOTE, 1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_SLASH,  1'b1, '{1'b1, NB_ONE,  '{CH_SLASH, 1'b1, 1'b1, 1'b1}, NO_RES}},
            '{CH_SLASH,  1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{CH_STAR,   1'b0, '{1'b0, NB_NONE, NO_RES, NO_RES}},
            '{8'h6B,     1'b1, '{1'b1, NB_ONE,  '{8'h00, 1'b0, 1'b1, 1'b1}, NO_RES}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
            send_byte(rows[i].text_byte, rows[i].is_final, rows[i].hand);
        texts++;

        while (items_sent < RAND_ITEMS)
        begin
            txt.delete();
            repeat ($urandom_range(3, 12))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        repeat ($urandom_range(1, 4))
                            txt_add(BYTE_W'($urandom_range(8'h61, 8'h7A)));
                    3:
                        txt_add(CH_NL);
                    4:
                    begin
                        txt_add(CH_DQUOTE);
                        repeat ($urandom_range(0, 4))
                        begin
                            if ($urandom_range(0, 4) == 0)
                                txt_add(CH_BSLASH);
                            txt_add(pick_body());
                        end
                        txt_add(CH_DQUOTE);
                    end
                    5:
                    begin
                        txt_add(CH_SQUOTE);
                        if ($urandom_range(0, 2) == 0)
                            txt_add(CH_BSLASH);
                        txt_add(pick_body());
                        txt_add(CH_SQUOTE);
                    end
                    6:
                    begin
                        txt_add(CH_SLASH);
                        txt_add(CH_SLASH);
                        repeat ($urandom_range(0, 5))
                            txt_add(pick_body());
                        txt_add(CH_NL);
                    end
                    7:
                    begin
                        txt_add(CH_SLASH);
                        txt_add(CH_STAR);
                        repeat ($urandom_range(0, 6))
                        begin
                            case ($urandom_range(0, 3))
                                0:       txt_add(CH_STAR);
                                1:       txt_add(CH_NL);
                                2:       txt_add(CH_SLASH);
                                default: txt_add(pick_body());
                            endcase
                        end
                        txt_add(CH_STAR);
                        txt_add(CH_SLASH);
                    end
                    8:
                    begin
                        txt_add(CH_SLASH);
                        txt_add(pick_body());
                    end
                    default:
                        txt_add(BYTE_W'($urandom_range(0, 255)));
                endcase
            end

            // Now and then the text stops short, which can leave a comment or literal open.
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, txt.size());
                txt = txt[0:cut-1];
            end

            // A run of texts with no idling on either side.
            calm = (texts >= 8 && texts < 14);
            foreach (txt[i])
                send_byte(txt[i], i == txt.size() - 1, '0);
            items_sent += txt.size();
            texts++;
        end

        in_ch.valid <= 1'b0;
        calm = 1'b0;
        @(posedge clk);
        while (strip_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Fed %0d source bytes over %0d texts: directed cases, then random code,",
                 items_in, texts);
        $display("literals, comments and noise; %0d result items checked, %0d mismatched.",
                 results_out, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cstr_pkg.sv
hw/rtl/cstr_in_if.sv
hw/rtl/cstr_out_if.sv
hw/rtl/cstr_front.sv
hw/rtl/cstr_fifo.sv
hw/rtl/cstr_back.sv
hw/rtl/c_comment_stripper.sv
hw/rtl/cstr_checker.sv
test/tb_c_comment_stripper.sv
